@@ src/lkc_pkg.sv @@
// Shared types and constants of the LRU key cache.
`default_nettype none
package lkc_pkg;

  localparam int KEY_W        = 63;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 20;

  // Per-cycle commands broadcast from the control unit to every cell.
  typedef struct packed {
    logic cmp;   // compare the lookup key against the held key
    logic upd;   // apply the shift and load for the current lookup
    logic hit;   // the lookup matched one of the held keys
    logic full;  // every cell holds a key
  } ctrl_t;

endpackage
`default_nettype wire

@@ src/lkc_cell.sv @@
// One cell of the recency chain: a key, its valid bit and its match flag.
`default_nettype none
module lkc_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lkc_pkg::ctrl_t           ctrl,
  input  wire logic [lkc_pkg::KEY_W-1:0] lookup_key,
  input  wire logic [lkc_pkg::KEY_W-1:0] younger_key,
  input  wire logic                     older_valid,
  input  wire logic                     younger_valid,
  input  wire logic                     prefix_match,
  output logic      [lkc_pkg::KEY_W-1:0] key_r,
  output logic                          valid_r,
  output logic                          match_r
);

  logic last_valid;
  logic first_empty;
  logic load;
  logic shift;

  // The youngest held key sits where the valid run ends; the first free
  // cell sits just past it.
  assign last_valid  = valid_r & ~younger_valid;
  assign first_empty = ~valid_r & older_valid;
  assign load  = ctrl.upd & ((ctrl.hit | ctrl.full) ? last_valid : first_empty);
  assign shift = ctrl.upd & (ctrl.hit ? prefix_match : ctrl.full) & ~load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end
      if (ctrl.cmp) begin
        match_r <= valid_r & (key_r == lookup_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= lookup_key;
    end else if (shift) begin
      key_r <= younger_key;
    end
  end

endmodule
`default_nettype wire

@@ src/lru_key_cache.sv @@
// Top level of the LRU key cache: control, cell chain and result register.
//
//  chan | dir | payload ports                                        | handshake
//  in   | in  | in_lookup_key                                        | in_valid, in_ready
//  out  | out | out_hit, out_evicted, out_evicted_key, out_occupancy | out_valid, out_ready
//
// Each lookup passes a compare state, in which every cell compares its key,
// and a shift state, in which the chain shifts and loads and the result is registered.
// A new lookup is taken in the shift cycle, as the current one completes.
// Reset empties the list at once; no clearing pass is needed.
// A result that is not taken holds the shift cycle, and input is then refused.
`default_nettype none
module lru_key_cache #(
  parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [lkc_pkg::KEY_W-1:0] in_lookup_key,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_hit,
  output logic                           out_evicted,
  output logic      [lkc_pkg::KEY_W-1:0] out_evicted_key,
  output logic      [lkc_pkg::OCC_W-1:0] out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t                     state_r;
  logic [lkc_pkg::KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic [31:0]                occ_wide;
  logic                       out_valid_r;
  logic                       hit_r;
  logic                       evicted_r;
  logic [lkc_pkg::KEY_W-1:0]  evicted_key_r;
  logic [lkc_pkg::OCC_W-1:0]  occupancy_r;

  lkc_pkg::ctrl_t             ctrl;
  logic                       upd_fire;
  logic                       any_hit;
  logic                       full;
  logic                       grow;

  logic [lkc_pkg::KEY_W-1:0]  cell_key   [CAPACITY];
  logic [CAPACITY-1:0]        cell_valid;
  logic [CAPACITY-1:0]        cell_match;
  logic [CAPACITY-1:0]        prefix_match;

  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || upd_fire;
  assign any_hit  = |cell_match;
  assign full     = cell_valid[CAPACITY-1];
  assign grow     = ~any_hit & ~full;
  assign fill_nxt = fill_r + CNT_W'(grow);
  assign occ_wide = 32'(fill_nxt);

  assign ctrl.cmp  = (state_r == S_CMP);
  assign ctrl.upd  = upd_fire;
  assign ctrl.hit  = any_hit;
  assign ctrl.full = full;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [lkc_pkg::KEY_W-1:0] younger_key;
      logic                      older_valid;
      logic                      younger_valid;

      // A hit at or below this cell shifts in the younger key, unless this cell loads the new one.
      assign prefix_match[g] = |cell_match[g:0];

      if (g == CAPACITY - 1) begin : g_end
        assign younger_key   = key_r;
        assign younger_valid = 1'b0;
      end else begin : g_mid
        assign younger_key   = cell_key[g+1];
        assign younger_valid = cell_valid[g+1];
      end
      if (g == 0) begin : g_head
        assign older_valid = 1'b1;
      end else begin : g_body
        assign older_valid = cell_valid[g-1];
      end

      lkc_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .lookup_key    (key_r),
        .younger_key   (younger_key),
        .older_valid   (older_valid),
        .younger_valid (younger_valid),
        .prefix_match  (prefix_match[g]),
        .key_r         (cell_key[g]),
        .valid_r       (cell_valid[g]),
        .match_r       (cell_match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && !upd_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r   <= in_lookup_key;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_fire) begin
            out_valid_r   <= 1'b1;
            hit_r         <= any_hit;
            evicted_r     <= full & ~any_hit;
            evicted_key_r <= (full & ~any_hit) ? cell_key[0] : '0;
            occupancy_r   <= occ_wide[lkc_pkg::OCC_W-1:0];
            fill_r        <= fill_nxt;
            if (in_valid) begin
              key_r   <= in_lookup_key;
              state_r <= S_CMP;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;
  assign out_occupancy   = occupancy_r;

endmodule
`default_nettype wire

@@ src/lkc_checker.sv @@
// Port-level checks on the LRU key cache and the bind that attaches them.
`default_nettype none
module lkc_checker #(
  parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_hit,
  input wire logic                      out_evicted,
  input wire logic [lkc_pkg::KEY_W-1:0] out_evicted_key,
  input wire logic [lkc_pkg::OCC_W-1:0] out_occupancy
);

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction reported together");

  // With nothing evicted the evicted key reads as zero.
  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == '0))
    else $error("evicted key not zero without an eviction");

  // An eviction only happens with the list full.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_occupancy == lkc_pkg::OCC_W'(CAPACITY)))
    else $error("eviction with the list not full");

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) && $stable(out_evicted)
      && $stable(out_evicted_key) && $stable(out_occupancy)))
    else $error("result changed while stalled");

  // Input is refused in the compare cycle that follows a taken lookup.
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("lookup taken in the compare cycle");

endmodule

bind lru_key_cache lkc_checker #(.CAPACITY(CAPACITY)) u_lkc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key),
  .out_occupancy   (out_occupancy)
);
`default_nettype wire
